[rtl/core/bfi_pkg.sv]
// Shared types, constants and the square-root table of the brightness fade interpolator.
package bfi_pkg;

  localparam int unsigned TimeBitsDef = 16;
  localparam int unsigned LvlW        = 8;
  localparam int unsigned RootW       = 12;
  localparam int unsigned ProgW       = 16;
  localparam int unsigned FullScale   = 255 * 256;
  localparam logic [ProgW-1:0] ProgMax = 16'hFFFF;
  localparam logic [6:0]  RoundBias   = 7'd127;
  // 2^23 / 255 rounded up: the quotient estimate is exact or one too large.
  localparam logic [15:0] RecipK      = 16'd32897;
  localparam int unsigned RecipSh     = 23;

  typedef logic [RootW-1:0] root_tab_t [256];

  // Item data that travels with each item down the pipeline.
  typedef struct packed {
    logic [LvlW-1:0]  s;
    logic [LvlW-1:0]  t;
    logic             done;
    logic             lin;
    logic [RootW-1:0] p0;
    logic [RootW-1:0] p1;
  } bfi_item_t;

  function automatic logic [RootW-1:0] isqrt(longint unsigned v);
    logic [RootW-1:0] root;
    longint unsigned  trial;
    root = '0;
    for (int i = RootW - 1; i >= 0; i--) begin
      trial = longint'(root | (RootW'(1) << i));
      if (trial * trial <= v) root = root | (RootW'(1) << i);
    end
    return root;
  endfunction

  function automatic root_tab_t build_root_tab();
    root_tab_t tab;
    for (int i = 0; i < 256; i++) tab[i] = isqrt(longint'(i) * FullScale);
    return tab;
  endfunction

  // floor(sqrt(level * 65280)) for every level.
  localparam root_tab_t RootTab = build_root_tab();

endpackage

[rtl/core/brightness_fade_interpolator.sv]
// Top level of the brightness fade interpolator.
// Usage: write linear_mode on cfg_we/cfg_wdata while idle (1 linear, 0 perceptual).
// Input channel in_*: start level, target level, elapsed and duration in ms; a
// transfer takes place when in_valid is high and in_stall low.
// Result channel out_*: level, fraction (1/256 steps) and done_res, one result
// per input item, in order.
// Pipeline: one input stage, sixteen divider stages of one quotient bit each and
// five back-end stages.
// Throughput: one item per cycle while out_stall is low; the divider pipeline sets the depth.
// Reset (synchronous, rst_n low) empties the pipeline and sets perceptual mode.
// When the receiver stalls, each stage holds its item and empty stages still
// fill, so input transfers continue until the pipeline is full.
module brightness_fade_interpolator import bfi_pkg::*; #(
  parameter int unsigned TIME_BITS = TimeBitsDef
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [LvlW-1:0] in_start_level,
  input  logic [LvlW-1:0] in_target_level,
  input  logic [15:0]     in_elapsed_ms,
  input  logic [15:0]     in_duration_ms,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [LvlW-1:0] out_level,
  output logic [LvlW-1:0] out_fraction,
  output logic            out_done_res
);
  logic                       lin_r;
  logic                       f_valid, f_stall, d_valid, d_stall;
  bfi_item_t                  f_item, d_item;
  logic [TIME_BITS+ProgW-1:0] f_dvd;
  logic [TIME_BITS-1:0]       f_dvs;
  logic [ProgW-1:0]           d_quot;

  // Mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_r <= 1'b0;
    end else if (cfg_we) begin
      lin_r <= cfg_wdata;
    end
  end

  bfi_front #(.TB(TIME_BITS)) u_front (
    .clk, .rst_n, .lin_mode(lin_r), .in_valid, .in_stall,
    .in_start_level, .in_target_level, .in_elapsed_ms, .in_duration_ms,
    .o_valid(f_valid), .o_stall(f_stall), .o_item(f_item),
    .o_dividend(f_dvd), .o_divisor(f_dvs)
  );

  bfi_div #(.TB(TIME_BITS)) u_div (
    .clk, .rst_n, .i_valid(f_valid), .i_stall(f_stall), .i_item(f_item),
    .i_dividend(f_dvd), .i_divisor(f_dvs),
    .o_valid(d_valid), .o_stall(d_stall), .o_item(d_item), .o_quot(d_quot)
  );

  bfi_back u_back (
    .clk, .rst_n, .i_valid(d_valid), .i_stall(d_stall), .i_item(d_item),
    .i_quot(d_quot), .out_valid, .out_stall, .out_level, .out_fraction,
    .out_done_res
  );
endmodule

[rtl/core/bfi_front.sv]
// Input stage: time masking, done test, division operands and root lookups.
module bfi_front import bfi_pkg::*; #(
  parameter int unsigned TB = TimeBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                lin_mode,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [LvlW-1:0]     in_start_level,
  input  logic [LvlW-1:0]     in_target_level,
  input  logic [15:0]         in_elapsed_ms,
  input  logic [15:0]         in_duration_ms,
  output logic                o_valid,
  input  logic                o_stall,
  output bfi_item_t           o_item,
  output logic [TB+ProgW-1:0] o_dividend,
  output logic [TB-1:0]       o_divisor
);
  logic [TB-1:0]       ti, tr;
  logic [LvlW-1:0]     delta;
  logic [TB+LvlW-1:0]  lin_prod;
  logic [TB+ProgW-1:0] dvd_nxt;
  bfi_item_t           item_nxt;
  logic                v_r;

  // Operand preparation.
  always_comb begin
    ti = in_elapsed_ms[TB-1:0];
    tr = in_duration_ms[TB-1:0];
    delta = (in_target_level >= in_start_level) ? in_target_level - in_start_level
                                                : in_start_level - in_target_level;
    lin_prod = delta * ti;
    if (lin_mode) dvd_nxt = (TB+ProgW)'(lin_prod);
    else          dvd_nxt = {ti, {ProgW{1'b0}}};
    item_nxt.s    = in_start_level;
    item_nxt.t    = in_target_level;
    item_nxt.done = (ti >= tr);
    item_nxt.lin  = lin_mode;
    item_nxt.p0   = RootTab[in_start_level];
    item_nxt.p1   = RootTab[in_target_level];
  end

  assign in_stall = v_r && o_stall;
  assign o_valid  = v_r;

  // Stage register; loads whenever it is empty or its content moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (!in_stall) begin
      v_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      o_item     <= item_nxt;
      o_dividend <= dvd_nxt;
      o_divisor  <= tr;
    end
  end
endmodule

[rtl/core/bfi_div.sv]
// Pipelined restoring divider: one quotient bit per stage, sixteen stages.
module bfi_div import bfi_pkg::*; #(
  parameter int unsigned TB = TimeBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                i_valid,
  output logic                i_stall,
  input  bfi_item_t           i_item,
  input  logic [TB+ProgW-1:0] i_dividend,
  input  logic [TB-1:0]       i_divisor,
  output logic                o_valid,
  input  logic                o_stall,
  output bfi_item_t           o_item,
  output logic [ProgW-1:0]    o_quot
);
  logic              v_r    [ProgW];
  logic [TB-1:0]     rem_r  [ProgW];
  logic [ProgW-1:0]  low_r  [ProgW];
  logic [ProgW-1:0]  quot_r [ProgW];
  logic [TB-1:0]     dvs_r  [ProgW];
  bfi_item_t         item_r [ProgW];
  logic              stl    [ProgW+1];

  assign stl[ProgW] = o_stall;
  assign i_stall    = stl[0];

  for (genvar k = 0; k < ProgW; k++) begin : g_stage
    logic             v_in;
    logic [TB-1:0]    rem_in, dvs_in;
    logic [ProgW-1:0] low_in, quot_in;
    bfi_item_t        item_in;
    logic [TB:0]      trial;
    logic             qbit;

    if (k == 0) begin : g_first
      assign v_in    = i_valid;
      assign rem_in  = i_dividend[TB+ProgW-1:ProgW];
      assign low_in  = i_dividend[ProgW-1:0];
      assign quot_in = '0;
      assign dvs_in  = i_divisor;
      assign item_in = i_item;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign low_in  = low_r[k-1];
      assign quot_in = quot_r[k-1];
      assign dvs_in  = dvs_r[k-1];
      assign item_in = item_r[k-1];
    end

    // Shift in the next dividend bit and try the subtraction.
    assign trial  = {rem_in, low_in[ProgW-1]};
    assign qbit   = (trial >= {1'b0, dvs_in});
    assign stl[k] = v_r[k] && stl[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (!stl[k]) begin
        v_r[k] <= v_in;
      end
      if (!stl[k] && v_in) begin
        rem_r[k]  <= qbit ? TB'(trial - {1'b0, dvs_in}) : trial[TB-1:0];
        low_r[k]  <= {low_in[ProgW-2:0], 1'b0};
        quot_r[k] <= {quot_in[ProgW-2:0], qbit};
        dvs_r[k]  <= dvs_in;
        item_r[k] <= item_in;
      end
    end
  end

  assign o_valid = v_r[ProgW-1];
  assign o_item  = item_r[ProgW-1];
  assign o_quot  = quot_r[ProgW-1];
endmodule

[rtl/core/bfi_back.sv]
// Back end: fade-in ease, root-domain interpolation, squaring, divide by 255, output register.
module bfi_back import bfi_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             i_valid,
  output logic             i_stall,
  input  bfi_item_t        i_item,
  input  logic [ProgW-1:0] i_quot,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [LvlW-1:0]  out_level,
  output logic [LvlW-1:0]  out_fraction,
  output logic             out_done_res
);
  localparam int unsigned NStg = 5;

  logic      v_r [NStg];
  logic      stl [NStg+1];
  bfi_item_t it1_r, it2_r, it3_r, it4_r;
  logic [ProgW-1:0] q1_r, q2_r, q3_r, q4_r;
  logic [31:0]      rsq1_r;
  logic [27:0]      a2_r;
  logic             up2_r;
  logic [23:0]      n4_r;
  logic [23:0]      n5_r;
  logic [16:0]      q04_r;

  assign stl[NStg] = out_stall;
  for (genvar k = 0; k < NStg; k++) begin : g_stl
    assign stl[k] = v_r[k] && stl[k+1];
  end
  assign i_stall = stl[0];

  // Stage 1: square of the remaining progress for the fade-in ease.
  logic [ProgW-1:0] r1;
  assign r1 = ProgMax - i_quot;

  // Stage 2: eased progress times the root distance.
  logic [ProgW-1:0] xe2;
  logic [RootW-1:0] d2;
  logic             up_root;
  logic [27:0]      a2_nxt;
  always_comb begin
    xe2 = (it1_r.t > it1_r.s) ? ProgMax - rsq1_r[31:16] : q1_r;
    up_root = (it1_r.p1 >= it1_r.p0);
    d2 = up_root ? it1_r.p1 - it1_r.p0 : it1_r.p0 - it1_r.p1;
  end
  assign a2_nxt = d2 * xe2;

  // Stage 3: interpolated root and its square.
  logic [RootW-1:0] p3;
  logic [28:0]      a3r;
  logic [23:0]      sq3;
  always_comb begin
    a3r = {1'b0, a2_r} + 29'(ProgMax);
    p3 = up2_r ? it2_r.p0 + a2_r[27:16] : it2_r.p0 - a3r[27:16];
  end
  assign sq3 = p3 * p3;

  // Stage 4: rounded square times the reciprocal of 255.
  logic [39:0] m4;
  assign m4 = n4_r * RecipK;

  // Stage 5: quotient correction, minimum step and result selection.
  logic [24:0]       back5;
  logic [ProgW-1:0]  b16;
  logic              any5;
  logic [LvlW-1:0]   lvl_nxt, frac_nxt, lin_lvl;
  always_comb begin
    back5 = {q04_r, 8'd0} - {8'd0, q04_r};
    b16 = (back5 > {1'b0, n5_r}) ? ProgW'(q04_r - 17'd1) : q04_r[ProgW-1:0];
    any5 = (it4_r.s != '0) || (it4_r.t != '0);
    lin_lvl = (it4_r.t >= it4_r.s) ? it4_r.s + q4_r[LvlW-1:0] : it4_r.s - q4_r[LvlW-1:0];
    if (it4_r.done) begin
      lvl_nxt  = it4_r.t;
      frac_nxt = '0;
    end else if (it4_r.lin) begin
      lvl_nxt  = (lin_lvl == '0 && any5) ? LvlW'(1) : lin_lvl;
      frac_nxt = '0;
    end else begin
      if (b16 == '0 && any5) b16 = ProgW'(1);
      lvl_nxt  = b16[15:8];
      frac_nxt = b16[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NStg; k++) v_r[k] <= 1'b0;
    end else begin
      if (!stl[0]) v_r[0] <= i_valid;
      for (int k = 1; k < NStg; k++) if (!stl[k]) v_r[k] <= v_r[k-1];
    end
    if (!stl[0] && i_valid) begin
      it1_r  <= i_item;
      q1_r   <= i_quot;
      rsq1_r <= r1 * r1;
    end
    if (!stl[1] && v_r[0]) begin
      it2_r <= it1_r;
      q2_r  <= q1_r;
      up2_r <= up_root;
      a2_r  <= a2_nxt;
    end
    if (!stl[2] && v_r[1]) begin
      it3_r <= it2_r;
      q3_r  <= q2_r;
      n4_r  <= sq3 + 24'(RoundBias);
    end
    if (!stl[3] && v_r[2]) begin
      it4_r <= it3_r;
      q4_r  <= q3_r;
      n5_r  <= n4_r;
      q04_r <= m4[RecipSh+16:RecipSh];
    end
    if (!stl[4] && v_r[3]) begin
      out_level    <= lvl_nxt;
      out_fraction <= frac_nxt;
      out_done_res <= it4_r.done;
    end
  end
  assign out_valid = v_r[4];

  a_done_frac: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> (out_fraction == '0))
    else $error("done result with nonzero fraction");
  a_lin_frac: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[3] && !stl[4] && it4_r.lin) |=> (out_fraction == '0))
    else $error("linear result with nonzero fraction");
  a_min_step: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[3] && !stl[4] && !it4_r.done && ((it4_r.s != '0) || (it4_r.t != '0)))
      |=> ((out_level != '0) || (out_fraction != '0)))
    else $error("brightness dropped to zero");
endmodule
